// ----- src/olt_pkg.sv -----
// Package for the ordered list table: data width, request codes and
// result status codes. No dependencies.
`timescale 1ns / 1ps

package olt_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned COUNT_W  = 7;

  // Request codes. Codes above CMD_SEARCH change nothing in the block and only report the current count.
  localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_POS  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SEARCH   = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_EMPTY     = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_e;

endpackage

// ----- src/olt_req_if.sv -----
// Request channel of the ordered list table: valid/ready plus payload.
// Depends on olt_pkg.
`timescale 1ns / 1ps

interface olt_req_if;
  import olt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [DATA_W-1:0] value;
  logic [POS_W-1:0]         position;

  modport source (output valid, output cmd, output value, output position, input ready);
  modport sink   (input valid, input cmd, input value, input position, output ready);
endinterface

// ----- src/olt_rsp_if.sv -----
// Response channel of the ordered list table: valid/ready plus payload.
// Depends on olt_pkg.
`timescale 1ns / 1ps

interface olt_rsp_if;
  import olt_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                found;
  logic [INDEX_W-1:0]  match_index;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, output status, output found, output match_index,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input found, input match_index,
                  input entry_count, output ready);
endinterface

// ----- src/olt_mem.sv -----
// Entry storage of the ordered list table: one write port and one read
// port with registered read data. Depends on olt_pkg.
`timescale 1ns / 1ps

module olt_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [olt_pkg::DATA_W-1:0]  wdata_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [olt_pkg::DATA_W-1:0]  rdata_o
);
  import olt_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/ordered_list_table_core.sv -----
// Ordered list table: a list of up to CAPACITY signed 32-bit values kept in one memory.
// Each entry moved is read and then written back one place over, and each entry compared is
// read and then checked against the requested value, in separate sequencer states; an insert
// at the tail moves nothing. One request is in flight at a time.
// Reset (rst_ni low, asynchronous) empties the list; memory contents are not cleared.
`timescale 1ns / 1ps

module ordered_list_table_core #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  olt_req_if.sink   req_i,
  olt_rsp_if.source rsp_o
);
  import olt_pkg::*;

  // Address width indexes the memory; count width also holds CAPACITY itself.
  localparam int unsigned AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  // Common widths for comparing the 6-bit position with the count, and for
  // masking count and index down to the result field widths.
  localparam int unsigned PXW = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned CXW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int unsigned IXW = (AW > INDEX_W) ? AW : INDEX_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PUT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DEL_RD,
    S_DEL_WR
  } state_e;

  // A separate flag marks a finished result waiting for the output register.
  state_e            state_q;
  logic              done_q;
  logic [CW-1:0]     count_q;
  logic [AW-1:0]     idx_q;
  logic [AW-1:0]     at_q;
  logic [CMD_W-1:0]  cmd_q;
  logic [DATA_W-1:0] value_q;
  status_e           status_q;
  logic              found_q;
  logic [AW-1:0]     match_q;

  logic                rsp_valid_q;
  logic [STATUS_W-1:0] rsp_status_q;
  logic                rsp_found_q;
  logic [INDEX_W-1:0]  rsp_index_q;
  logic [COUNT_W-1:0]  rsp_count_q;

  // Memory port signals.
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  // Helper values for the sequencer.
  logic              req_fire;
  logic              out_free;
  logic [PXW-1:0]    pos_ext;
  logic [PXW-1:0]    cnt_pos_ext;
  logic [AW-1:0]     ins_at;
  logic [CW-1:0]     idx_plus1;
  logic [CW:0]       idx_plus2;
  logic              is_insert;
  logic              is_lookup;
  logic [CXW-1:0]    cnt_out_ext;
  logic [IXW-1:0]    idx_out_ext;

  assign req_fire  = req_i.valid && req_i.ready;
  assign out_free  = !rsp_valid_q || rsp_o.ready;
  // A new request is taken whenever the sequencer is free, even while the
  // previous result still waits in the output register.
  assign req_i.ready = (state_q == S_IDLE) && !done_q;

  assign is_insert = (req_i.cmd == CMD_INS_HEAD) || (req_i.cmd == CMD_INS_TAIL) ||
                     (req_i.cmd == CMD_INS_POS);
  assign is_lookup = (req_i.cmd == CMD_DELETE) || (req_i.cmd == CMD_SEARCH);

  // Insert position: head, tail, or the requested place clamped to the tail.
  // The list is not full when this is used, so the count fits the address.
  assign pos_ext     = PXW'(req_i.position);
  assign cnt_pos_ext = PXW'(count_q);

  always_comb begin
    ins_at = AW'(count_q);
    if (req_i.cmd == CMD_INS_HEAD) begin
      ins_at = '0;
    end else if (req_i.cmd == CMD_INS_POS && pos_ext < cnt_pos_ext) begin
      ins_at = AW'(req_i.position);
    end
  end

  assign idx_plus1 = CW'(idx_q) + CW'(1);
  assign idx_plus2 = (CW + 1)'(idx_q) + (CW + 1)'(2);

  // Memory control follows the sequencer state. Shifting toward the tail
  // reads entry idx-1 and writes it to idx; closing a gap reads idx+1 and
  // writes it to idx.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = mem_rdata;
    mem_raddr = idx_q;
    case (state_q)
      S_SHIFT_RD: mem_raddr = idx_q - AW'(1);
      S_SHIFT_WR: mem_we = 1'b1;
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = at_q;
        mem_wdata = value_q;
      end
      S_SCAN_RD:  mem_raddr = idx_q;
      S_DEL_RD:   mem_raddr = AW'(idx_plus1);
      S_DEL_WR:   mem_we = 1'b1;
      default: ;
    endcase
  end

  olt_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Result fields are masked to their port widths.
  assign cnt_out_ext = CXW'(count_q);
  assign idx_out_ext = IXW'(match_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      done_q       <= 1'b0;
      count_q      <= '0;
      idx_q        <= '0;
      at_q         <= '0;
      cmd_q        <= '0;
      value_q      <= '0;
      status_q     <= STATUS_OK;
      found_q      <= 1'b0;
      match_q      <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_status_q <= '0;
      rsp_found_q  <= 1'b0;
      rsp_index_q  <= '0;
      rsp_count_q  <= '0;
    end else begin
      // Move a finished result into the output register once it is free.
      if (done_q && out_free) begin
        done_q       <= 1'b0;
        rsp_valid_q  <= 1'b1;
        rsp_status_q <= status_q;
        rsp_found_q  <= found_q;
        rsp_index_q  <= idx_out_ext[INDEX_W-1:0];
        rsp_count_q  <= cnt_out_ext[COUNT_W-1:0];
      end else if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            cmd_q    <= req_i.cmd;
            value_q  <= req_i.value;
            found_q  <= 1'b0;
            match_q  <= '0;
            if (is_insert) begin
              if (count_q == CW'(CAPACITY)) begin
                status_q <= STATUS_FULL;
                idx_q    <= '0;
                done_q   <= 1'b1;
              end else begin
                status_q <= STATUS_OK;
                at_q     <= ins_at;
                idx_q    <= AW'(count_q);
                // Nothing to move when inserting at the tail.
                state_q <= (ins_at == AW'(count_q)) ? S_PUT : S_SHIFT_RD;
              end
            end else if (is_lookup) begin
              idx_q <= '0;
              if (count_q == '0) begin
                status_q <= STATUS_EMPTY;
                done_q   <= 1'b1;
              end else begin
                status_q <= STATUS_OK;
                state_q  <= S_SCAN_RD;
              end
            end else begin
              // Unused codes report the current count and change nothing.
              status_q <= STATUS_OK;
              idx_q    <= '0;
              done_q   <= 1'b1;
            end
          end
        end

        S_SHIFT_RD: state_q <= S_SHIFT_WR;

        S_SHIFT_WR: begin
          idx_q   <= idx_q - AW'(1);
          state_q <= ((idx_q - AW'(1)) == at_q) ? S_PUT : S_SHIFT_RD;
        end

        S_PUT: begin
          count_q <= count_q + CW'(1);
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end

        S_SCAN_RD: state_q <= S_SCAN_CMP;

        S_SCAN_CMP: begin
          if (mem_rdata == value_q) begin
            found_q <= 1'b1;
            match_q <= idx_q;
            if (cmd_q == CMD_DELETE && idx_plus1 < count_q) begin
              state_q <= S_DEL_RD;
            end else begin
              if (cmd_q == CMD_DELETE) begin
                count_q <= count_q - CW'(1);
              end
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end
          end else if (idx_plus1 == count_q) begin
            status_q <= STATUS_NOT_FOUND;
            done_q   <= 1'b1;
            state_q  <= S_IDLE;
          end else begin
            idx_q   <= AW'(idx_plus1);
            state_q <= S_SCAN_RD;
          end
        end

        S_DEL_RD: state_q <= S_DEL_WR;

        S_DEL_WR: begin
          // Entry idx now holds its successor; continue while one remains.
          if (idx_plus2 < (CW + 1)'(count_q)) begin
            idx_q   <= AW'(idx_plus1);
            state_q <= S_DEL_RD;
          end else begin
            count_q <= count_q - CW'(1);
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.found       = rsp_found_q;
  assign rsp_o.match_index = rsp_index_q;
  assign rsp_o.entry_count = rsp_count_q;

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for ordered_list_table_core: random and directed list requests,
// with every response predicted and compared field by field.
// Depends on olt_pkg, olt_req_if, olt_rsp_if and the core itself.
`timescale 1ns / 1ps

module tb;
  import olt_pkg::*;

  localparam int unsigned CAPACITY     = 64;
  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned POOL_SIZE    = 12;
  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned TAIL_CYCLES  = 150;
  localparam int unsigned CMD_LAST     = (1 << CMD_W) - 1;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  position;
  } list_req_t;

  typedef struct packed {
    status_e            status;
    logic               found;
    logic [INDEX_W-1:0] match_index;
    logic [COUNT_W-1:0] entry_count;
  } list_rsp_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  olt_req_if req_if ();
  olt_rsp_if rsp_if ();

  ordered_list_table_core #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Requests waiting to be driven, and responses the list contents call for.
  list_req_t pending_reqs[$];
  list_rsp_t due_results[$];

  // Predicted list contents, updated as each request is accepted.
  logic [DATA_W-1:0] list_vals[CAPACITY];
  int unsigned       list_len = 0;

  // Shadow of the list on the stimulus side, used to aim deletes and searches at
  // values that are present and to know when the list is full or empty.
  logic [DATA_W-1:0] gen_list[$];
  logic [DATA_W-1:0] value_pool[POOL_SIZE];

  int unsigned reqs_total    = 0;
  int unsigned reqs_accepted = 0;
  int unsigned mismatches    = 0;
  int unsigned idle_cycles   = 0;
  int unsigned cycle_no      = 0;
  int unsigned req_gap       = 0;
  int unsigned rsp_hold      = 0;
  logic        req_taken     = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Applies one request to the predicted list and returns the response it yields.
  function automatic list_rsp_t update_list(list_req_t rq);
    list_rsp_t   res;
    int unsigned at;
    int unsigned hit;
    int unsigned i;
    res.status      = STATUS_OK;
    res.found       = 1'b0;
    res.match_index = '0;
    if (rq.cmd == CMD_INS_HEAD || rq.cmd == CMD_INS_TAIL || rq.cmd == CMD_INS_POS) begin
      if (list_len >= CAPACITY) begin
        res.status = STATUS_FULL;
      end else begin
        if (rq.cmd == CMD_INS_HEAD) begin
          at = 0;
        end else if (rq.cmd == CMD_INS_TAIL) begin
          at = list_len;
        end else begin
          at = (32'(rq.position) < list_len) ? 32'(rq.position) : list_len;
        end
        for (i = list_len; i > at; i--) list_vals[i] = list_vals[i-1];
        list_vals[at] = rq.value;
        list_len++;
      end
    end else if (rq.cmd == CMD_DELETE || rq.cmd == CMD_SEARCH) begin
      if (list_len == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        hit = list_len;
        for (i = 0; i < list_len; i++) begin
          if (hit == list_len && list_vals[i] == rq.value) hit = i;
        end
        if (hit == list_len) begin
          res.status = STATUS_NOT_FOUND;
        end else begin
          res.found       = 1'b1;
          res.match_index = hit[INDEX_W-1:0];
          if (rq.cmd == CMD_DELETE) begin
            for (i = hit; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
            list_len--;
          end
        end
      end
    end
    res.entry_count = list_len[COUNT_W-1:0];
    return res;
  endfunction

  // Mostly no gap, some short ones and a few long ones; a stretch that recurs with the cycle
  // counter runs with no idling at all.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (cycle_no % 1024 < 128) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic [DATA_W-1:0] pick_present();
    if (gen_list.size() == 0) return $urandom;
    return gen_list[$urandom_range(0, gen_list.size() - 1)];
  endfunction

  // Half the positions fall inside the list or at its end, half anywhere in the field.
  function automatic logic [POS_W-1:0] pick_pos();
    int unsigned lim;
    lim = (gen_list.size() < (1 << POS_W) - 1) ? gen_list.size() : (1 << POS_W) - 1;
    if ($urandom_range(0, 1) == 1) return POS_W'($urandom_range(0, lim));
    return POS_W'($urandom_range(0, (1 << POS_W) - 1));
  endfunction

  task automatic add_req(logic [CMD_W-1:0] c, logic [DATA_W-1:0] v, logic [POS_W-1:0] p);
    int i;
    pending_reqs.push_back('{cmd: c, value: v, position: p});
    reqs_total++;
    if (c == CMD_INS_HEAD || c == CMD_INS_TAIL || c == CMD_INS_POS) begin
      if (gen_list.size() < CAPACITY) begin
        if (c == CMD_INS_HEAD) begin
          gen_list.push_front(v);
        end else if (c == CMD_INS_TAIL || int'(p) >= gen_list.size()) begin
          gen_list.push_back(v);
        end else begin
          gen_list.insert(int'(p), v);
        end
      end
    end else if (c == CMD_DELETE) begin
      for (i = 0; i < gen_list.size(); i++) begin
        if (gen_list[i] == v) begin
          gen_list.delete(i);
          break;
        end
      end
    end
  endtask

  // An unused command code now and then; it does not count as a random item.
  task automatic maybe_noise();
    if ($urandom_range(0, 49) == 0) begin
      add_req(CMD_W'($urandom_range(CMD_SEARCH + 1, CMD_LAST)), $urandom, POS_W'($urandom));
    end
  endtask

  task automatic note_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("%s", what);
  endtask

  // Request driver: holds an item until it is taken, then idles or moves on.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (req_if.valid && !req_taken) begin
      req_if.valid <= 1'b1;
    end else if (req_gap > 0) begin
      req_if.valid <= 1'b0;
      req_gap      <= req_gap - 1;
    end else if (pending_reqs.size() > 0) begin
      req_if.valid    <= 1'b1;
      req_if.cmd      <= pending_reqs[0].cmd;
      req_if.value    <= pending_reqs[0].value;
      req_if.position <= pending_reqs[0].position;
      pending_reqs.delete(0);
      req_gap         <= pick_gap();
    end else begin
      req_if.valid <= 1'b0;
    end
  end

  // Response side stalls on its own random pattern.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (rsp_hold > 0) begin
      rsp_if.ready <= 1'b0;
      rsp_hold     <= rsp_hold - 1;
    end else begin
      rsp_if.ready <= 1'b1;
      rsp_hold     <= pick_gap();
    end
  end

  // Monitor: predicts on each accepted request and checks each accepted response.
  always @(posedge clk_i) begin
    list_rsp_t want;
    if (rst_ni) begin
      cycle_no  <= cycle_no + 1;
      req_taken <= req_if.valid && req_if.ready;
      if (req_if.valid && req_if.ready) begin
        due_results.push_back(update_list('{cmd: req_if.cmd, value: req_if.value,
                                            position: req_if.position}));
        reqs_accepted <= reqs_accepted + 1;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (due_results.size() == 0) begin
          note_mismatch($sformatf("unexpected response: status %0d found %0d index %0d count %0d",
                                  rsp_if.status, rsp_if.found, rsp_if.match_index,
                                  rsp_if.entry_count));
        end else begin
          want = due_results.pop_front();
          if (rsp_if.status !== want.status || rsp_if.found !== want.found ||
              rsp_if.match_index !== want.match_index ||
              rsp_if.entry_count !== want.entry_count) begin
            note_mismatch({$sformatf("response mismatch: expected status %0d found %0d %s",
                                     want.status, want.found, ""),
                           $sformatf("index %0d count %0d, got status %0d found %0d ",
                                     want.match_index, want.entry_count,
                                     rsp_if.status, rsp_if.found),
                           $sformatf("index %0d count %0d",
                                     rsp_if.match_index, rsp_if.entry_count)});
          end
        end
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned n;
    int unsigned r;
    int unsigned i;
    req_if.valid    = 1'b0;
    req_if.cmd      = CMD_INS_HEAD;
    req_if.value    = '0;
    req_if.position = '0;
    rsp_if.ready    = 1'b0;

    // Directed part: empty list, field extremes, position corner cases,
    // duplicates, head and tail matches, misses and unused codes.
    add_req(CMD_SEARCH,   32'h0000_0000, 6'd0);
    add_req(CMD_DELETE,   32'h0000_0000, 6'd63);
    add_req(CMD_INS_POS,  32'h7FFF_FFFF, 6'd63);
    add_req(CMD_INS_HEAD, 32'h8000_0000, 6'd0);
    add_req(CMD_INS_TAIL, 32'hFFFF_FFFF, 6'd0);
    add_req(CMD_INS_POS,  32'h0000_0000, 6'd1);
    add_req(CMD_INS_POS,  32'h0000_0001, 6'd4);
    add_req(CMD_INS_POS,  32'h5555_5555, 6'd40);
    add_req(CMD_INS_HEAD, 32'h0000_0000, 6'd0);
    add_req(CMD_SEARCH,   32'h0000_0000, 6'd0);
    add_req(CMD_SEARCH,   32'h5555_5555, 6'd0);
    add_req(CMD_SEARCH,   32'h0000_3039, 6'd0);
    add_req(CMD_DELETE,   32'h0000_0000, 6'd0);
    add_req(CMD_SEARCH,   32'h0000_0000, 6'd0);
    add_req(CMD_DELETE,   32'h5555_5555, 6'd0);
    add_req(CMD_DELETE,   32'h0000_0007, 6'd0);
    add_req(CMD_INS_POS,  32'hAAAA_AAAA, 6'd0);
    add_req(CMD_W'(CMD_SEARCH + 1), 32'hAAAA_AAAA, 6'd42);
    add_req(CMD_W'(CMD_LAST), 32'h5555_5555, 6'd21);
    add_req(CMD_DELETE,   32'h8000_0000, 6'd0);

    // Random part: fill the list to full, hit it with refused inserts, then drain
    // it to empty, all with values drawn mostly from a small pool so that
    // duplicates and matches are common.
    n = 0;
    while (n < RANDOM_ITEMS) begin
      for (i = 0; i < POOL_SIZE; i++) begin
        r = $urandom_range(0, 9);
        value_pool[i] = (r == 0) ? 32'h8000_0000 : (r == 1) ? 32'h7FFF_FFFF : $urandom;
      end
      while (gen_list.size() < CAPACITY) begin
        if ($urandom_range(0, 99) < 85) begin
          add_req(CMD_W'($urandom_range(CMD_INS_HEAD, CMD_INS_POS)), pick_value(), pick_pos());
        end else begin
          add_req(CMD_SEARCH, pick_value(), pick_pos());
        end
        n++;
        maybe_noise();
      end
      repeat (4) begin
        add_req(CMD_W'($urandom_range(CMD_INS_HEAD, CMD_INS_POS)), $urandom, pick_pos());
        n++;
      end
      add_req(CMD_SEARCH, pick_present(), pick_pos());
      add_req(CMD_SEARCH, $urandom, pick_pos());
      n += 2;
      while (gen_list.size() > 0) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          add_req(CMD_DELETE, pick_present(), pick_pos());
        end else if (r < 88) begin
          add_req(CMD_DELETE, pick_value(), pick_pos());
        end else begin
          add_req(CMD_SEARCH, (r < 94) ? pick_present() : pick_value(), pick_pos());
        end
        n++;
        maybe_noise();
      end
      add_req(CMD_DELETE, pick_value(), pick_pos());
      add_req(CMD_SEARCH, pick_value(), pick_pos());
      n += 2;
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (reqs_accepted != reqs_total || due_results.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (mismatches == 0 && due_results.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
